// ===== hw/rtl/dq_pkg.sv =====
// dq_pkg: types and constants shared by the double-ended queue cells and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // fixed field widths of the stream payload
    localparam int FIELD_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int OUT_DATA_W  = 104;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]       t_count;

    typedef enum logic [1:0] {
        FUNC_PUSH_R = 2'd0,
        FUNC_POP_L  = 2'd1,
        FUNC_POP_R  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SHIFT = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     last;   // cell holds the rightmost item
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/dq_cell.sv =====
// dq_cell: one storage cell of the deque row; loads, shifts from its right neighbour or holds.
// Depends on dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_cell (
    input  wire logic               i_clk,
    input  wire dq_pkg::t_cell_ctrl i_ctrl,
    input  wire dq_pkg::t_value     i_load,
    input  wire dq_pkg::t_value     i_right,
    output dq_pkg::t_value          o_value,
    output dq_pkg::t_value          o_tap
);

    dq_pkg::t_value r_value;
    dq_pkg::t_value n_value;

    always_comb begin
        case (i_ctrl.op)
            dq_pkg::CELL_LOAD:  n_value = i_load;
            dq_pkg::CELL_SHIFT: n_value = i_right;
            default:            n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // only the rightmost cell feeds the OR tree
    assign o_tap   = i_ctrl.last ? r_value : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// double_ended_queue: top level, control sequencer over a row of dq_cell storage cells.
// Depends on dq_pkg and dq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Use
//   Slave stream carries one operation per beat: tuser is the function code
//   (push right, pop left, pop right, none) and tdata the value to push.
//   Master stream returns exactly one result beat per operation: popped value,
//   ends of the queue after the operation, empty flag and item count in tdata,
//   status (ok, pop on empty, push on full) in tuser.
// Structure
//   Items sit in a row of cells, leftmost item in cell 0. A push loads the cell
//   at the fill count, a pop on the left shifts every cell one place left from
//   its neighbour, a pop on the right only drops the count. The rightmost value
//   comes from an OR of the cell taps, only the last occupied cell driving it.
// Timing
//   One operation at a time: accept, cell update, result capture. The result
//   beat goes valid when it is captured, after the cell update, and the next
//   beat is accepted the cycle after the result is captured, so a new operation
//   is taken only once the last has left the three-step sequencer.
// Reset and stall
//   Synchronous active-low reset empties the queue (count zero);
//   cell contents are not cleared, empty ends read 0. When the receiver stalls,
//   the result beat holds, the next operation may still be accepted and run,
//   and it waits in the capture step until the output register frees.

module double_ended_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // slave stream
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [31:0]   i_s_axis_tdata,   // [31:0] push_value
    input  wire logic [1:0]    i_s_axis_tuser,   // [1:0] func
    // master stream
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [dq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata, // [31:0] popped_value,
                                                 // [63:32] left_value,
                                                 // [95:64] right_value, [96] is_empty,
                                                 // [101:97] item_count, [103:102] zero
    output logic [1:0]         o_m_axis_tuser    // [1:0] status
);

    localparam int N = dq_pkg::CAPACITY;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_RESULT = 2'd2
    } t_state;

    t_state            r_state;
    dq_pkg::t_func     r_func;
    dq_pkg::t_value    r_push;
    dq_pkg::t_count    r_count;
    dq_pkg::t_status   r_status;
    dq_pkg::t_value    r_popped;
    logic              r_out_valid;
    logic [dq_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [1:0]        r_out_user;

    dq_pkg::t_cell_ctrl w_ctrl  [N];
    dq_pkg::t_value     w_value [N];
    dq_pkg::t_value     w_tap   [N];
    dq_pkg::t_value     w_right;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_full;
    logic               w_empty;

    assign w_full     = (r_count == dq_pkg::t_count'(N));
    assign w_empty    = (r_count == '0);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // ---- cell row
    for (genvar i = 0; i < N; i++) begin : g_cell
        dq_pkg::t_value w_nb;
        if (i == N - 1) begin : g_end
            assign w_nb = '0;
        end else begin : g_mid
            assign w_nb = w_value[i+1];
        end

        always_comb begin
            w_ctrl[i].last = (r_count == dq_pkg::t_count'(i + 1));
            w_ctrl[i].op   = dq_pkg::CELL_HOLD;
            if (r_state == S_EXEC) begin
                case (r_func)
                    dq_pkg::FUNC_PUSH_R: begin
                        if (r_count == dq_pkg::t_count'(i)) begin
                            w_ctrl[i].op = dq_pkg::CELL_LOAD;
                        end
                    end
                    dq_pkg::FUNC_POP_L: begin
                        if (!w_empty) begin
                            w_ctrl[i].op = dq_pkg::CELL_SHIFT;
                        end
                    end
                    default: w_ctrl[i].op = dq_pkg::CELL_HOLD;
                endcase
            end
        end

        dq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[i]),
            .i_load  (r_push),
            .i_right (w_nb),
            .o_value (w_value[i]),
            .o_tap   (w_tap[i])
        );
    end

    // rightmost value: at most one tap is non-zero
    always_comb begin
        w_right = '0;
        for (int k = 0; k < N; k++) begin
            w_right = w_right | w_tap[k];
        end
    end

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // capture sets the beat valid, a taken beat clears it
            if (r_state == S_RESULT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_func  <= dq_pkg::t_func'(i_s_axis_tuser);
                        r_push  <= dq_pkg::t_value'(i_s_axis_tdata);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_func)
                        dq_pkg::FUNC_PUSH_R: begin
                            r_popped <= '0;
                            if (w_full) begin
                                r_status <= dq_pkg::ST_FULL;
                            end else begin
                                r_status <= dq_pkg::ST_OK;
                                r_count  <= r_count + 1'b1;
                            end
                        end
                        dq_pkg::FUNC_POP_L: begin
                            if (w_empty) begin
                                r_status <= dq_pkg::ST_EMPTY;
                                r_popped <= '0;
                            end else begin
                                r_status <= dq_pkg::ST_OK;
                                r_popped <= w_value[0];
                                r_count  <= r_count - 1'b1;
                            end
                        end
                        dq_pkg::FUNC_POP_R: begin
                            if (w_empty) begin
                                r_status <= dq_pkg::ST_EMPTY;
                                r_popped <= '0;
                            end else begin
                                r_status <= dq_pkg::ST_OK;
                                r_popped <= w_right;
                                r_count  <= r_count - 1'b1;
                            end
                        end
                        default: begin
                            r_status <= dq_pkg::ST_OK;
                            r_popped <= '0;
                        end
                    endcase
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_data <= dq_pkg::OUT_DATA_W'({
                            dq_pkg::COUNT_W'(r_count),
                            w_empty,
                            dq_pkg::FIELD_W'(w_right),
                            w_empty ? dq_pkg::FIELD_W'(0) : dq_pkg::FIELD_W'(w_value[0]),
                            dq_pkg::FIELD_W'(r_popped)});
                        r_out_user <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // ---- checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dq_pkg::t_count'(N))
        else $error("fill count beyond capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[96] == (o_m_axis_tdata[101:97] == '0)))
        else $error("empty flag disagrees with item count");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[96]) |-> (o_m_axis_tdata[95:32] == '0))
        else $error("end values not zero on empty queue");

    a_error_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_func != dq_pkg::FUNC_NONE
            && ((r_func == dq_pkg::FUNC_PUSH_R && w_full)
                || (r_func != dq_pkg::FUNC_PUSH_R && w_empty)))
        |=> $stable(r_count))
        else $error("state changed on rejected operation");

endmodule

`default_nettype wire

// ===== verif/double_ended_queue_test.sv =====
// double_ended_queue_test: self-checking testbench for the double-ended queue top level.
// Drives operation beats on the slave stream and checks every result beat against a
// shadow ring kept here. Depends on dq_pkg and double_ended_queue.
`timescale 1ns / 1ps

module double_ended_queue_test;

    // one result beat, as predicted
    typedef struct packed {
        dq_pkg::t_value  popped;
        dq_pkg::t_status status;
        dq_pkg::t_value  left;
        dq_pkg::t_value  right;
        logic            empty;
        logic [4:0]      count;
    } t_dq_result;

    typedef logic [$clog2(dq_pkg::CAPACITY)-1:0] t_slot_idx;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;  // [31:0] push_value
    logic [1:0]   s_axis_tuser  = dq_pkg::FUNC_NONE;  // [1:0] func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;        // [31:0] popped, [63:32] left, [95:64] right,
                                       // [96] is_empty, [101:97] item_count
    logic [1:0]   m_axis_tuser;        // [1:0] status

    // shadow of the ring: slots, left pointer, fill count
    dq_pkg::t_value shadow_slot [dq_pkg::CAPACITY];
    int     shadow_left = 0;
    int     shadow_fill = 0;

    t_dq_result pending_results[$];

    int tx_idle_pct  = 23;
    int rx_idle_pct  = 63;
    int hold_request = 0;
    int hold_left    = 0;

    int mismatch_count = 0;
    int beats_sent     = 0;
    int beats_checked  = 0;
    int n_push         = 0;
    int n_pop          = 0;
    int n_full_reject  = 0;
    int n_empty_reject = 0;
    int n_query        = 0;

    double_ended_queue u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // slot index of position base + offs on the ring
    function automatic t_slot_idx ring_pos(int base, int offs);
        return t_slot_idx'((base + offs) % dq_pkg::CAPACITY);
    endfunction

    // Apply one operation to the shadow ring and return the beat it should produce.
    function automatic t_dq_result next_deque_result(dq_pkg::t_func f, dq_pkg::t_value v);
        t_dq_result r;
        r = '0;
        r.status = dq_pkg::ST_OK;
        case (f)
            dq_pkg::FUNC_PUSH_R: begin
                if (shadow_fill == dq_pkg::CAPACITY) begin
                    r.status = dq_pkg::ST_FULL;
                    n_full_reject++;
                end else begin
                    shadow_slot[ring_pos(shadow_left, shadow_fill)] = v;
                    shadow_fill++;
                    n_push++;
                end
            end
            dq_pkg::FUNC_POP_L: begin
                if (shadow_fill == 0) begin
                    r.status = dq_pkg::ST_EMPTY;
                    n_empty_reject++;
                end else begin
                    r.popped    = shadow_slot[ring_pos(shadow_left, 0)];
                    shadow_left = (shadow_left + 1) % dq_pkg::CAPACITY;
                    shadow_fill--;
                    n_pop++;
                end
            end
            dq_pkg::FUNC_POP_R: begin
                if (shadow_fill == 0) begin
                    r.status = dq_pkg::ST_EMPTY;
                    n_empty_reject++;
                end else begin
                    r.popped = shadow_slot[ring_pos(shadow_left, shadow_fill - 1)];
                    shadow_fill--;
                    n_pop++;
                end
            end
            default: begin
                n_query++;
            end
        endcase
        if (shadow_fill != 0) begin
            r.left  = shadow_slot[ring_pos(shadow_left, 0)];
            r.right = shadow_slot[ring_pos(shadow_left, shadow_fill - 1)];
        end
        r.empty = (shadow_fill == 0);
        r.count = shadow_fill[4:0];
        return r;
    endfunction

    // Receiver: random stalls, or a counted hold-off when a test asks for one.
    always @(posedge clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Result checker: every accepted result beat against the oldest expectation.
    always @(posedge clk) begin
        t_dq_result e;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("popped_value", e.popped, m_axis_tdata[31:0]);
                check_field("status",       32'(e.status), 32'(m_axis_tuser));
                check_field("left_value",   e.left,   m_axis_tdata[63:32]);
                check_field("right_value",  e.right,  m_axis_tdata[95:64]);
                check_field("is_empty",     32'(e.empty), 32'(m_axis_tdata[96]));
                check_field("item_count",   32'(e.count), 32'(m_axis_tdata[101:97]));
                beats_checked++;
            end
        end
    end

    // Offer one operation beat, with random idle cycles first; returns once accepted.
    // tvalid is left high so the next call can follow in the same step.
    task automatic issue_op(dq_pkg::t_func f, dq_pkg::t_value v);
        t_dq_result exp_r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= v;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        exp_r = next_deque_result(f, v);
        pending_results.insert(pending_results.size(), exp_r);
        beats_sent++;
    endtask

    // Stop offering and wait until every expected result has been seen.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
    endtask

    // Empty pops, a query, the value extremes and pops from both ends.
    task automatic test_empty_and_extremes();
        issue_op(dq_pkg::FUNC_POP_L, 32'h1234_5678);
        issue_op(dq_pkg::FUNC_POP_R, 32'hFFFF_FFFF);
        issue_op(dq_pkg::FUNC_NONE,  32'h0);
        issue_op(dq_pkg::FUNC_PUSH_R, 32'h0000_0000);
        issue_op(dq_pkg::FUNC_PUSH_R, 32'hFFFF_FFFF);
        issue_op(dq_pkg::FUNC_NONE,  32'hDEAD_BEEF);
        issue_op(dq_pkg::FUNC_POP_R, 32'h0);
        issue_op(dq_pkg::FUNC_POP_L, 32'h0);
    endtask

    // Fill to capacity, push on full, then take one from each end.
    task automatic test_fill_and_full();
        int k;
        k = 0;
        while (shadow_fill < dq_pkg::CAPACITY) begin
            issue_op(dq_pkg::FUNC_PUSH_R, (k[0] ? 32'hAAAA_AAAA : 32'h5555_5555) ^ k);
            k++;
        end
        issue_op(dq_pkg::FUNC_PUSH_R, 32'hCAFE_F00D);
        issue_op(dq_pkg::FUNC_POP_L, 32'h0);
        issue_op(dq_pkg::FUNC_POP_R, 32'h0);
    endtask

    // Random traffic in fill and drain bursts so the ring wraps, fills and empties often.
    task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
        bit             filling;
        int             burst_left;
        int             roll;
        dq_pkg::t_func  f;
        dq_pkg::t_value v;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        filling     = 1'b1;
        burst_left  = 0;
        for (int i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
                filling    = !filling;
                burst_left = $urandom_range(40, 4);
            end
            burst_left--;
            roll = $urandom_range(99);
            if (roll < 5)
                f = dq_pkg::FUNC_NONE;
            else if (roll < (filling ? 75 : 30))
                f = dq_pkg::FUNC_PUSH_R;
            else
                f = $urandom_range(1) ? dq_pkg::FUNC_POP_L : dq_pkg::FUNC_POP_R;
            roll = $urandom_range(99);
            v = (roll < 8) ? 32'h0 : (roll < 16) ? 32'hFFFF_FFFF : $urandom;
            issue_op(f, v);
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the output register fills and the input stalls.
    task automatic test_output_hold_off();
        tx_idle_pct  = 0;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
            issue_op($urandom_range(99) < 60 ? dq_pkg::FUNC_PUSH_R : dq_pkg::FUNC_POP_L,
                     $urandom);
    endtask

    // Sender pauses until every result has come back, then resumes.
    task automatic test_pause_until_drained();
        for (int i = 0; i < 10; i++)
            issue_op(dq_pkg::t_func'($urandom_range(3)), $urandom);
        wait_drained();
        for (int i = 0; i < 10; i++)
            issue_op(dq_pkg::t_func'($urandom_range(3)), $urandom);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles 23 in 100, receiver 63 in 100
        test_empty_and_extremes();
        test_fill_and_full();
        test_random_traffic(560, 23, 63);
        // roles swapped
        test_random_traffic(560, 63, 23);
        // no idling at all
        test_random_traffic(560, 0, 0);
        test_output_hold_off();
        test_pause_until_drained();

        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d result beats never arrived", pending_results.size());
            mismatch_count++;
        end

        $display("run covered %0d operation beats, %0d result beats checked",
                 beats_sent, beats_checked);
        $display("pushes %0d, pops %0d, push on full %0d, pop on empty %0d, queries %0d",
                 n_push, n_pop, n_full_reject, n_empty_reject, n_query);
        if (mismatch_count == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

    // watchdog, well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("[double_ended_queue] ERROR");
        $finish;
    end

endmodule
